// ----- sv/pdh_pkg.sv -----
// Package for the pair distance histogram block: command codes, widths, shared types.
// No dependencies.
`default_nettype none
package pdh_pkg;
  localparam int unsigned BINS   = 1024;
  localparam int unsigned IDX_W  = $clog2(BINS);
  localparam int unsigned CNT_W  = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_PARTICLE = 2'd1,
    CMD_PAIR     = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_MAX_RANGE = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT = 2'd2;

  typedef struct packed {
    logic [23:0]      max_range;
    logic [23:0]      bin_width;
    logic [CNT_W-1:0] bin_count;
  } cfg_t;
endpackage
`default_nettype wire

// ----- sv/pdh_if.sv -----
// Valid/ready channel interfaces for input and result beats.
// No dependencies.
`default_nettype none
interface pdh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [47:0] dist_sq;
  logic [15:0] size_a;
  logic [15:0] size_b;
  logic [9:0]  read_index;
  modport source (output valid, cmd, dist_sq, size_a, size_b, read_index, input ready);
  modport sink   (input valid, cmd, dist_sq, size_a, size_b, read_index, output ready);
endinterface

interface pdh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_count;
  logic [31:0] scaled_count;
  logic [31:0] diam_total;
  logic [63:0] diam_cube_total;
  logic [15:0] particles_seen;
  modport source (output valid, plain_count, scaled_count, diam_total, diam_cube_total,
                  particles_seen, input ready);
  modport sink   (input valid, plain_count, scaled_count, diam_total, diam_cube_total,
                  particles_seen, output ready);
endinterface
`default_nettype wire

// ----- sv/pdh_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pdh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- sv/pdh_alu.sv -----
// Shared restoring subtract/shift unit: one step of square root or division per cycle.
// No dependencies.
`default_nettype none
module pdh_alu (
  input  wire logic [49:0] rem_i,   // partial remainder
  input  wire logic [49:0] sub_i,   // trial subtrahend
  output logic      [49:0] diff_o,
  output logic             ge_o
);
  logic [50:0] d;
  assign d      = {1'b0, rem_i} - {1'b0, sub_i};
  assign ge_o   = ~d[50];
  assign diff_o = d[49:0];
endmodule
`default_nettype wire

// ----- sv/pair_distance_histogram.sv -----
// Top level of the pair distance histogram block.
// Depends on pdh_pkg, pdh_if, pdh_ram, pdh_alu.
//
// Use: input beats arrive on in_ch (cmd, dist_sq, size_a, size_b, read_index);
// one result beat leaves on out_ch for every input beat. Registers max_range,
// bin_width, bin_count sit on the APB port at byte addresses 0, 4, 8.
// Timing: one item at a time. A particle beat passes S_MUL1, S_MUL2 and S_OUT
// (two registered multiplies for the cube). A read passes S_RD, S_RDOUT and
// S_OUT. A pair beat runs through one shared subtractor: 24 square-root
// steps, 37 scaled-divide steps and two 24-step bin divides, with a memory
// read-modify-write per histogram, then S_OUT.
// Clear walks all BINS entries of both RAMs, one per cycle; reset starts the
// same pass but sends no result beat. in_ch.ready is low during it (APB
// writes are still taken).
// A result is held in an output register until out_ch.ready; the block takes
// the next beat only once the result has gone.
`default_nettype none
module pair_distance_histogram (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pdh_in_if.sink           in_ch,
  pdh_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int unsigned IW = pdh_pkg::IDX_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLR   = 11'b00000000010,
    S_MUL1  = 11'b00000000100,
    S_MUL2  = 11'b00000001000,
    S_SQRT  = 11'b00000010000,
    S_SDIV  = 11'b00000100000,
    S_BDIV  = 11'b00001000000,
    S_RD    = 11'b00010000000,
    S_WR    = 11'b00100000000,
    S_RDOUT = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  pdh_pkg::cfg_t cfg_q;
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_range <= 24'd327680;
      cfg_q.bin_width <= 24'd6554;
      cfg_q.bin_count <= 11'd1024;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pdh_pkg::REG_MAX_RANGE: cfg_q.max_range <= pwdata[23:0];
        pdh_pkg::REG_BIN_WIDTH: cfg_q.bin_width <= pwdata[23:0];
        pdh_pkg::REG_BIN_COUNT: cfg_q.bin_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      pdh_pkg::REG_MAX_RANGE: prdata = {8'd0, cfg_q.max_range};
      pdh_pkg::REG_BIN_WIDTH: prdata = {8'd0, cfg_q.bin_width};
      pdh_pkg::REG_BIN_COUNT: prdata = {21'd0, cfg_q.bin_count};
      default:                prdata = 32'd0;
    endcase
  end

  // effective width and last bin
  localparam int unsigned CNT_W_L = pdh_pkg::CNT_W;
  logic [23:0]    w_eff;
  logic [CNT_W_L-1:0] last_bin;
  always_comb begin
    w_eff = (cfg_q.bin_width == 24'd0) ? 24'd1 : cfg_q.bin_width;
    if (cfg_q.bin_count == '0) last_bin = '0;
    else if (cfg_q.bin_count > CNT_W_L'(pdh_pkg::BINS)) last_bin = CNT_W_L'(pdh_pkg::BINS - 1);
    else last_bin = cfg_q.bin_count - 1'b1;
  end

  // item registers
  logic [1:0]  cmd_q;
  logic [47:0] dsq_q;
  logic [15:0] a_q;
  logic [16:0] s_q;
  logic [9:0]  ridx_q;
  // sums
  logic [31:0] dsum_q;
  logic [63:0] csum_q;
  logic [15:0] tally_q;
  logic [31:0] sq_q;       // a*a
  logic [47:0] cube;       // a*a*a
  // iteration
  logic [49:0] rem_q;
  logic [36:0] quo_q;      // shift register of quotient/root bits
  logic [5:0]  step_q;
  logic [23:0] r_q;        // plain distance
  logic [23:0] rs_q;       // scaled distance (low 24 bits of the quotient)
  logic        rs_ok_q;    // scaled value is binnable
  logic        hsel_q;     // 0 plain, 1 scaled
  logic        hit_q;      // current histogram gets an update
  logic        init_q;     // clearing pass after reset, no result beat
  logic [IW-1:0] addr_q;
  // results
  logic [31:0] pc_q, sc_q;
  logic        ovalid_q;

  assign cube = sq_q * a_q;

  // shared unit
  logic [49:0] alu_rem, alu_sub, alu_diff;
  logic        alu_ge;
  pdh_alu u_alu (.rem_i(alu_rem), .sub_i(alu_sub), .diff_o(alu_diff), .ge_o(alu_ge));

  // square root: rem accumulates two bits a step; trial = {root, 01}
  logic [49:0] sqrt_rem;
  assign sqrt_rem = {rem_q[47:0], dsq_q[47:46]};
  always_comb begin
    alu_rem = '0;
    alu_sub = '0;
    unique case (state_q)
      S_SQRT: begin
        alu_rem = sqrt_rem;
        alu_sub = {24'd0, quo_q[23:0], 2'b01};
      end
      S_SDIV: begin
        alu_rem = {rem_q[48:0], quo_q[36]};
        alu_sub = {33'd0, s_q};
      end
      S_BDIV: begin
        alu_rem = {rem_q[48:0], quo_q[23]};
        alu_sub = {26'd0, w_eff};
      end
      default: ;
    endcase
  end

  // RAMs
  logic          p_we, s_we;
  logic [31:0]   p_rd, s_rd, wdata;
  assign wdata = (state_q == S_CLR) ? 32'd0 : ((hsel_q ? s_rd : p_rd) + 32'd2);
  assign p_we  = (state_q == S_CLR) || (state_q == S_WR && !hsel_q && hit_q);
  assign s_we  = (state_q == S_CLR) || (state_q == S_WR &&  hsel_q && hit_q);
  pdh_ram #(.WIDTH(32), .DEPTH(pdh_pkg::BINS)) u_plain (
    .clk_i, .we_i(p_we), .addr_i(addr_q), .wdata_i(wdata), .rdata_o(p_rd));
  pdh_ram #(.WIDTH(32), .DEPTH(pdh_pkg::BINS)) u_scaled (
    .clk_i, .we_i(s_we), .addr_i(addr_q), .wdata_i(wdata), .rdata_o(s_rd));

  assign in_ch.ready           = (state_q == S_IDLE) && !ovalid_q;
  assign out_ch.valid          = ovalid_q;
  assign out_ch.plain_count    = pc_q;
  assign out_ch.scaled_count   = sc_q;
  assign out_ch.diam_total     = dsum_q;
  assign out_ch.diam_cube_total = csum_q;
  assign out_ch.particles_seen = tally_q;

  logic in_fire;
  assign in_fire = in_ch.valid & in_ch.ready;

  // bin index from quotient, saturated to the last bin
  logic [23:0] bq;
  logic [IW-1:0] bidx;
  assign bq   = {quo_q[22:0], alu_ge};
  assign bidx = (bq > 24'(last_bin)) ? IW'(last_bin) : bq[IW-1:0];

  // scaled quotient done value
  logic [36:0] sq_fin;
  assign sq_fin = {quo_q[35:0], alu_ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:
        if (in_fire) begin
          unique case (pdh_pkg::cmd_e'(in_ch.cmd))
            pdh_pkg::CMD_CLEAR:    state_d = S_CLR;
            pdh_pkg::CMD_PARTICLE: state_d = S_MUL1;
            pdh_pkg::CMD_PAIR:     state_d = S_SQRT;
            default:               state_d = S_RD;
          endcase
        end
      S_CLR:   if (addr_q == IW'(pdh_pkg::BINS - 1)) state_d = init_q ? S_IDLE : S_OUT;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_OUT;
      S_SQRT:  if (step_q == 6'd23) state_d = S_SDIV;
      S_SDIV:  if (step_q == 6'd36) state_d = S_BDIV;
      S_BDIV:  if (step_q == 6'd23) state_d = S_RD;
      S_RD:    state_d = (cmd_q == pdh_pkg::CMD_READ) ? S_RDOUT : S_WR;
      S_WR:    state_d = hsel_q ? S_OUT : S_BDIV;
      S_RDOUT: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      addr_q   <= '0;
      ovalid_q <= 1'b0;
      step_q   <= '0;
      hsel_q   <= 1'b0;
      init_q   <= 1'b1;
      dsum_q   <= '0;
      csum_q   <= '0;
      tally_q  <= '0;
      cmd_q    <= pdh_pkg::CMD_CLEAR;
    end else begin
      state_q <= state_d;
      if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          cmd_q  <= in_ch.cmd;
          dsq_q  <= in_ch.dist_sq;
          a_q    <= in_ch.size_a;
          s_q    <= {1'b0, in_ch.size_a} + {1'b0, in_ch.size_b};
          ridx_q <= in_ch.read_index;
          addr_q <= (in_ch.cmd == pdh_pkg::CMD_CLEAR) ? '0 : in_ch.read_index[IW-1:0];
          rem_q  <= '0;
          quo_q  <= '0;
          step_q <= '0;
          hsel_q <= 1'b0;
        end
        S_CLR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == IW'(pdh_pkg::BINS - 1)) begin
            init_q  <= 1'b0;
            dsum_q  <= '0;
            csum_q  <= '0;
            tally_q <= '0;
          end
        end
        S_MUL1: sq_q <= a_q * a_q;
        S_MUL2: begin
          csum_q  <= csum_q + {16'd0, cube};
          dsum_q  <= dsum_q + 32'(a_q);
          tally_q <= tally_q + 16'd1;
        end
        S_SQRT: begin
          dsq_q <= {dsq_q[45:0], 2'b00};
          if (step_q == 6'd23) begin
            step_q <= 6'd0;
            r_q    <= {quo_q[22:0], alu_ge};
            // dividend r<<13 fed MSB first from quo
            quo_q  <= {quo_q[22:0], alu_ge, 13'd0};
            rem_q  <= '0;
          end else begin
            step_q <= step_q + 6'd1;
            rem_q  <= alu_ge ? alu_diff : sqrt_rem;
            quo_q  <= {quo_q[35:0], alu_ge};
          end
        end
        S_SDIV: begin
          if (step_q == 6'd36) begin
            step_q  <= 6'd0;
            rs_ok_q <= (s_q != 17'd0) && (sq_fin < 37'(cfg_q.max_range));
            rs_q    <= sq_fin[23:0];
            quo_q   <= {13'd0, r_q};
            rem_q   <= '0;
            hit_q   <= r_q < cfg_q.max_range;
          end else begin
            step_q <= step_q + 6'd1;
            rem_q  <= alu_ge ? alu_diff : {rem_q[48:0], quo_q[36]};
            quo_q  <= {quo_q[35:0], alu_ge};
          end
        end
        S_BDIV: begin
          rem_q  <= alu_ge ? alu_diff : {rem_q[48:0], quo_q[23]};
          quo_q  <= {quo_q[35:0], alu_ge};
          step_q <= (step_q == 6'd23) ? 6'd0 : step_q + 6'd1;
          if (step_q == 6'd23) addr_q <= bidx;
        end
        S_WR: if (!hsel_q) begin
          hsel_q <= 1'b1;
          hit_q  <= rs_ok_q;
          quo_q  <= {13'd0, rs_q};
          rem_q  <= '0;
        end
        default: ;
      endcase
      if (state_q == S_OUT) begin
        ovalid_q <= 1'b1;
        if (cmd_q == pdh_pkg::CMD_READ) begin
          // read index at or beyond BINS returns zero
          if ({1'b0, ridx_q} < 11'(pdh_pkg::BINS)) begin
            pc_q <= p_rd;
            sc_q <= s_rd;
          end else begin
            pc_q <= '0;
            sc_q <= '0;
          end
        end else begin
          pc_q <= '0;
          sc_q <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire
